>>> sv/msfdr_pkg.sv
// ----------------------------------------------------------------------------
// msfdr_pkg
// Shared types, codes and constants of the multi-source frame decimation
// router: transaction payloads, event kinds, route codes, shared-unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package msfdr_pkg;

    // Field widths
    localparam int KIND_W      = 2;
    localparam int SRC_W       = 4;
    localparam int ROUTE_W     = 2;
    localparam int NUM_W       = 32;
    localparam int PHASE_W     = 3;
    localparam int INTERVAL_W  = 3;
    // Width that holds any source count in the supported range (up to 256)
    localparam int SRC_RANGE_W = 9;

    // Default source count
    localparam int MAX_SOURCES_DEF = 16;

    // APB port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 3'd1;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_FRAME     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END_ALL   = 2'd3;

    // Route codes
    localparam logic [ROUTE_W-1:0] ROUTE_INFER = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_SKIP  = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_ERROR = 2'd2;
    localparam logic [ROUTE_W-1:0] ROUTE_EVENT = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SRC_W-1:0]  source_id;
    } in_item_t;

    typedef struct packed {
        logic [ROUTE_W-1:0] route;
        logic [NUM_W-1:0]   frame_number;
    } out_item_t;

    // Shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_CMP_LE  = 2'd0,
        ALU_MOD_INC = 2'd1,
        ALU_INC     = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t               op;
        logic [NUM_W-1:0]      opa;
        logic [SRC_W-1:0]      opb;
        logic [INTERVAL_W-1:0] modulus;
    } alu_req_t;

endpackage

`default_nettype wire

>>> sv/msfdr_ram.sv
// ----------------------------------------------------------------------------
// msfdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msfdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/msfdr_alu.sv
// ----------------------------------------------------------------------------
// msfdr_alu
// Shared arithmetic unit: source compare, batch phase step modulo the
// interval, and frame counter increment.
// ----------------------------------------------------------------------------
`default_nettype none

module msfdr_alu
    import msfdr_pkg::*;
(
    input  wire alu_req_t         req,
    output logic      [NUM_W-1:0] result
);

    // (phase + 1) mod n by restoring subtraction; a zero modulus acts as one
    function automatic logic [PHASE_W-1:0] mod_inc(
        input logic [PHASE_W-1:0]    a,
        input logic [INTERVAL_W-1:0] n
    );
        logic [PHASE_W:0]        r;
        logic [INTERVAL_W-1:0]   nn;
        logic [PHASE_W+INTERVAL_W:0] d;
        r  = {1'b0, a} + {{PHASE_W{1'b0}}, 1'b1};
        nn = (n == '0) ? INTERVAL_W'(1) : n;
        for (int k = PHASE_W; k >= 0; k--) begin
            d = (PHASE_W+INTERVAL_W+1)'(nn) << k;
            if ((PHASE_W+INTERVAL_W+1)'(r) >= d) begin
                r = r - d[PHASE_W:0];
            end
        end
        return r[PHASE_W-1:0];
    endfunction

    always_comb begin
        case (req.op)
            ALU_CMP_LE: begin
                result = {{(NUM_W-1){1'b0}}, (req.opa[SRC_W-1:0] <= req.opb)};
            end
            ALU_MOD_INC: begin
                result = {{(NUM_W-PHASE_W){1'b0}},
                          mod_inc(req.opa[PHASE_W-1:0], req.modulus)};
            end
            ALU_INC: begin
                result = req.opa + NUM_W'(1);
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/multi_source_frame_decimation_router_top.sv
// A frame transaction passes the BATCH, PHASE and COUNT states before its result
// shows in DONE, an event only BATCH; the block then holds the result until taken.
// One transaction at a time: the next is accepted only once the result is taken.
// Reset: synchronous active-low aresetn clears all sources, phase and control.
// ----------------------------------------------------------------------------
// multi_source_frame_decimation_router_top
// Routes frames of interleaved sources to inference or skip by batch phase,
// tracks source registration and keeps a per-source frame counter in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_source_frame_decimation_router_top
    import msfdr_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input transactions
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // Result transactions
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BATCH = 5'b00010,
        ST_PHASE = 5'b00100,
        ST_COUNT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [SRC_W-1:0]        src_reg, src_next;
    logic [INTERVAL_W-1:0]   interval_reg;
    logic [MAX_SOURCES-1:0]  registered_reg, registered_next;
    logic [MAX_SOURCES-1:0]  pending_reg, pending_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic                    seen_reg, seen_next;
    logic [SRC_W-1:0]        prev_reg, prev_next;
    logic                    start_reg, start_next;
    out_item_t               result_reg, result_next;

    logic                    cfg_write;
    logic [SRC_RANGE_W-1:0]  src_wide;
    logic                    src_ok;
    logic [IDX_W-1:0]        idx;
    logic                    src_live;

    alu_req_t                alu_req;
    logic [NUM_W-1:0]        alu_res;

    logic                    ram_we;
    logic [NUM_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [NUM_W-1:0]        ram_rdata;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_INTERVAL)
                       ? {{(APB_DATA_W-INTERVAL_W){1'b0}}, interval_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_write && paddr[APB_ADDR_W-1] == REG_INTERVAL) begin
            interval_reg <= pwdata[INTERVAL_W-1:0];
        end
    end

    // Source decode
    assign src_wide = {{(SRC_RANGE_W-SRC_W){1'b0}}, src_reg};
    assign src_ok   = (src_wide < SRC_RANGE_W'(MAX_SOURCES));
    assign idx      = src_wide[IDX_W-1:0];
    assign src_live = src_ok && registered_reg[idx];

    // Shared arithmetic unit
    msfdr_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    // Frame counter store
    msfdr_ram #(
        .WIDTH (NUM_W),
        .DEPTH (MAX_SOURCES)
    ) u_counter_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        src_next        = src_reg;
        registered_next = registered_reg;
        pending_next    = pending_reg;
        phase_next      = phase_reg;
        seen_next       = seen_reg;
        prev_next       = prev_reg;
        start_next      = start_reg;
        result_next     = result_reg;
        alu_req.op      = ALU_CMP_LE;
        alu_req.opa     = {{(NUM_W-SRC_W){1'b0}}, src_reg};
        alu_req.opb     = prev_reg;
        alu_req.modulus = interval_reg;
        ram_we          = 1'b0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        s_ready         = 1'b0;
        m_valid         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    src_next   = s_data.source_id;
                    state_next = ST_BATCH;
                end
            end
            ST_BATCH: begin
                // Compare with previous source, fetch counter, apply events
                ram_re      = 1'b1;
                result_next = '{route: ROUTE_EVENT, frame_number: '0};
                case (kind_reg)
                    KIND_FRAME: begin
                        start_next = !seen_reg || alu_res[0];
                        prev_next  = src_reg;
                        state_next = ST_PHASE;
                    end
                    KIND_START: begin
                        if (src_ok) begin
                            registered_next[idx] = 1'b1;
                            pending_next[idx]    = 1'b0;
                            ram_we               = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    KIND_END: begin
                        if (src_ok) begin
                            registered_next[idx] = 1'b0;
                        end
                        state_next = ST_DONE;
                    end
                    KIND_END_ALL: begin
                        registered_next = '0;
                        state_next      = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PHASE: begin
                // On a new batch advance the phase, mark registered sources on phase zero
                alu_req.op  = ALU_MOD_INC;
                alu_req.opa = {{(NUM_W-PHASE_W){1'b0}}, phase_reg};
                if (start_reg) begin
                    phase_next = seen_reg ? alu_res[PHASE_W-1:0] : '0;
                    if (phase_next == '0) begin
                        pending_next = pending_reg | registered_reg;
                    end
                end
                seen_next  = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                // Route the frame and bump its counter
                alu_req.op  = ALU_INC;
                alu_req.opa = ram_rdata;
                if (src_live) begin
                    ram_we    = 1'b1;
                    ram_wdata = alu_res;
                    result_next.frame_number = ram_rdata;
                    if (phase_reg == '0 || pending_reg[idx]) begin
                        result_next.route = ROUTE_INFER;
                        pending_next[idx] = 1'b0;
                    end else begin
                        result_next.route = ROUTE_SKIP;
                    end
                end else begin
                    result_next = '{route: ROUTE_ERROR, frame_number: '0};
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until taken
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_data = result_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            registered_reg <= '0;
            phase_reg      <= '0;
            seen_reg       <= 1'b0;
            prev_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            registered_reg <= registered_next;
            phase_reg      <= phase_next;
            seen_reg       <= seen_next;
            prev_reg       <= prev_next;
        end
    end

    // Payload and per-source flags written before use
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        src_reg     <= src_next;
        start_reg   <= start_next;
        pending_reg <= pending_next;
        result_reg  <= result_next;
    end

    // Only one transaction in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input taken while a result is pending");

    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after acceptance");

    a_no_number: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.route == ROUTE_ERROR || m_data.route == ROUTE_EVENT))
        |-> (m_data.frame_number == '0))
        else $error("frame number set on error or event result");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != {PHASE_W{1'b1}})
        else $error("batch phase out of range");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-source frame decimation router. Frames and
// stream events go in over a valid/ready channel with random gaps. Routes come
// back under random back-pressure, with one long hold-off that fills the block.
// A scoreboard class predicts each route and frame number and checks every
// result in order. The batch interval is swept over its whole range via APB.
// ----------------------------------------------------------------------------

import msfdr_pkg::*;

// Scoreboard: tracks source registration, batch phase and frame counts.
// It queues the route that each accepted transaction must produce.
class route_predictor;
    logic [INTERVAL_W-1:0] interval;
    bit                    registered    [MAX_SOURCES_DEF];
    logic [NUM_W-1:0]      frame_count   [MAX_SOURCES_DEF];
    bit                    infer_pending [MAX_SOURCES_DEF];
    logic [PHASE_W-1:0]    batch_phase;
    bit                    seen_frame;
    logic [SRC_W-1:0]      prev_source;
    out_item_t             expected_routes[$];
    int                    errors;

    function new();
        interval    = INTERVAL_RESET;
        batch_phase = '0;
        seen_frame  = 1'b0;
        prev_source = '0;
        errors      = 0;
        foreach (registered[i]) begin
            registered[i]    = 1'b0;
            frame_count[i]   = '0;
            infer_pending[i] = 1'b0;
        end
    endfunction

    // Advance the phase; on phase 0 mark every live source pending
    function void open_batch();
        int span;
        span = (interval == 0) ? 1 : int'(interval);
        if (!seen_frame)
            batch_phase = '0;
        else
            batch_phase = PHASE_W'((int'(batch_phase) + 1) % span);
        if (batch_phase == 0) begin
            foreach (registered[i])
                if (registered[i])
                    infer_pending[i] = 1'b1;
        end
    endfunction

    // Note an accepted input transaction and queue its route
    function void accept_item(in_item_t item);
        out_item_t route_exp;
        int        s;
        s = int'(item.source_id);
        route_exp.route        = ROUTE_EVENT;
        route_exp.frame_number = '0;
        case (item.kind)
            KIND_FRAME: begin
                if (!seen_frame || item.source_id <= prev_source)
                    open_batch();
                seen_frame  = 1'b1;
                prev_source = item.source_id;
                if (!registered[s]) begin
                    route_exp.route = ROUTE_ERROR;
                end else begin
                    route_exp.frame_number = frame_count[s];
                    frame_count[s] = frame_count[s] + 1'b1;
                    if (batch_phase == 0 || infer_pending[s]) begin
                        route_exp.route  = ROUTE_INFER;
                        infer_pending[s] = 1'b0;
                    end else begin
                        route_exp.route = ROUTE_SKIP;
                    end
                end
            end
            KIND_START: begin
                registered[s]    = 1'b1;
                frame_count[s]   = '0;
                infer_pending[s] = 1'b0;
            end
            KIND_END: begin
                registered[s] = 1'b0;
            end
            KIND_END_ALL: begin
                foreach (registered[i])
                    registered[i] = 1'b0;
            end
            default: ;
        endcase
        expected_routes.push_back(route_exp);
    endfunction

    // Compare a result transaction with the oldest queued route
    function void check_route(out_item_t got);
        out_item_t route_exp;
        if (expected_routes.size() == 0) begin
            $display("%0t: unexpected result, route %0d frame %0d",
                     $time, got.route, got.frame_number);
            errors++;
            return;
        end
        route_exp = expected_routes.pop_front();
        if (got.route !== route_exp.route) begin
            $display("%0t: route mismatch, expected %0d actual %0d",
                     $time, route_exp.route, got.route);
            errors++;
        end
        if (got.frame_number !== route_exp.frame_number) begin
            $display("%0t: frame_number mismatch, expected %0d actual %0d",
                     $time, route_exp.frame_number, got.frame_number);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int HOLD_OFF_CYCLES  = 250;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int ITEMS_PER_PHASE  = 90;
    localparam int NUM_PHASES       = 9;
    localparam logic [APB_ADDR_W-1:0] INTERVAL_ADDR = {REG_INTERVAL, 2'b00};

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    wire                   s_ready;
    in_item_t              s_data  = '0;
    wire                   m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    route_predictor sb;
    bit             quiet    = 1'b0;
    bit             hold_req = 1'b0;
    int             phase_items;
    int             idle_cycles = 0;

    multi_source_frame_decimation_router_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Observe both channels and feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.accept_item(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_route(m_data);
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // Offer one transaction, after an optional gap, and hold until accepted
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SRC_W-1:0] src);
        in_item_t item;
        item.kind      = kind;
        item.source_id = src;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        phase_items++;
    endtask

    // Drop valid and wait until every queued route has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_routes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write of the batch interval: setup cycle, then access cycle
    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INTERVAL_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.interval = value;
    endtask

    initial begin : stimulus
        int                intervals [NUM_PHASES];
        int                p;
        int                pick;
        int                n;
        logic [SRC_W-1:0]  src;

        sb = new();
        intervals = '{1, 7, 0, 3, 2, 5, 4, 6, 7};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first frame from an unregistered source, registration,
        // re-registration, source end, end of all streams, equal ids
        send_item(KIND_FRAME,   4'd0);
        send_item(KIND_START,   4'd0);
        send_item(KIND_START,   4'd15);
        send_item(KIND_START,   4'd9);
        send_item(KIND_FRAME,   4'd0);
        send_item(KIND_FRAME,   4'd9);
        send_item(KIND_FRAME,   4'd15);
        send_item(KIND_FRAME,   4'd15);
        send_item(KIND_START,   4'd9);
        send_item(KIND_FRAME,   4'd9);
        send_item(KIND_END,     4'd15);
        send_item(KIND_FRAME,   4'd15);
        send_item(KIND_END_ALL, 4'd15);
        send_item(KIND_FRAME,   4'd0);
        send_item(KIND_START,   4'd0);
        send_item(KIND_START,   4'd6);
        send_item(KIND_FRAME,   4'd6);
        send_item(KIND_FRAME,   4'd0);
        wait_drained();

        // Interval 2: a source missing from the inference batch catches up
        write_interval(3'd2);
        send_item(KIND_FRAME, 4'd0);
        send_item(KIND_FRAME, 4'd6);
        send_item(KIND_FRAME, 4'd6);
        send_item(KIND_FRAME, 4'd0);
        send_item(KIND_FRAME, 4'd6);
        send_item(KIND_FRAME, 4'd0);

        // Random: batches of ascending frames, events and a little noise
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_interval(intervals[p][INTERVAL_W-1:0]);
            if (p == 2)
                hold_req = 1'b1;
            quiet = (p == NUM_PHASES - 1);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    // register, preferring a source not yet live
                    src = SRC_W'($urandom_range(0, 15));
                    if (sb.registered[src])
                        src = SRC_W'($urandom_range(0, 15));
                    send_item(KIND_START, src);
                end else if (pick < 5) begin
                    send_item(KIND_END, SRC_W'($urandom_range(0, 15)));
                end else if (pick == 5) begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(KIND_END_ALL, SRC_W'($urandom_range(0, 15)));
                end else if (pick == 6) begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_item(KIND_FRAME, SRC_W'($urandom_range(0, 15)));
                end else begin
                    // one batch: live sources in order, some dropped, a rare unregistered one added
                    for (int s = 0; s < MAX_SOURCES_DEF; s++) begin
                        if (sb.registered[s] ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 39) == 0))
                            send_item(KIND_FRAME, SRC_W'(s));
                    end
                end
            end
        end
        wait_drained();

        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
sv/msfdr_pkg.sv
sv/msfdr_ram.sv
sv/msfdr_alu.sv
sv/multi_source_frame_decimation_router_top.sv
tb/tb.sv
